>>> design/sha_pkg.sv
// ============================================================================
// SHA-256 hasher package
// Round constants, initial hash values and the controller-to-datapath
// command types shared by the hasher modules.
// ============================================================================
package sha_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned ROUNDS   = 64;
    localparam int unsigned BLOCK_B  = 64;
    localparam int unsigned CHAIN_N  = 8;
    localparam int unsigned SCHED_N  = 16;
    localparam int unsigned LEN_W    = 64;
    localparam int unsigned PART_W   = 64;

    localparam logic [BYTE_W-1:0] PAD_MARK = 8'h80;

    localparam logic [WORD_W-1:0] INIT_HASH [CHAIN_N] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    localparam logic [WORD_W-1:0] ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Source of the byte pushed into the block store
    typedef enum logic [1:0] {
        SRC_DATA = 2'd0,
        SRC_MARK = 2'd1,
        SRC_ZERO = 2'd2,
        SRC_LEN  = 2'd3
    } push_src_t;

    typedef struct packed {
        logic        push;
        push_src_t   src;
        logic [2:0]  len_idx;
        logic        load;
        logic        round;
        logic [5:0]  round_idx;
        logic        add;
        logic        finish;
        logic [1:0]  part_idx;
    } dp_cmd_t;

endpackage

>>> design/sha_ifs.sv
// ============================================================================
// SHA-256 hasher channels
// Valid/ready channels for message bytes in and digest parts out.
// ============================================================================
interface sha_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;

    modport source (output valid, output data_byte, output byte_present,
                    output end_of_message, input ready);
    modport sink   (input valid, input data_byte, input byte_present,
                    input end_of_message, output ready);
endinterface

interface sha_digest_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_part;
    logic [1:0]  part_index;
    logic        last_part;

    modport source (output valid, output digest_part, output part_index,
                    output last_part, input ready);
    modport sink   (input valid, input digest_part, input part_index,
                    input last_part, output ready);
endinterface

>>> design/sha_ctrl.sv
// ============================================================================
// SHA-256 hasher controller
// Sequences byte intake, padding, compression rounds and digest transfers.
// ============================================================================
module sha_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              byte_present,
    input  logic              end_of_message,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        part_index,
    output logic              last_part,
    output sha_pkg::dp_cmd_t  cmd
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_MARK  = 8'b0000_0010,
        S_ZERO  = 8'b0000_0100,
        S_LEN   = 8'b0000_1000,
        S_LOAD  = 8'b0001_0000,
        S_ROUND = 8'b0010_0000,
        S_ADD   = 8'b0100_0000,
        S_EMIT  = 8'b1000_0000
    } state_t;

    localparam logic [5:0] FILL_LAST = 6'd63;
    localparam logic [5:0] FILL_LEN  = 6'd55;

    state_t     state_reg, state_next;
    logic [5:0] fill_reg, fill_next;
    logic [5:0] round_reg, round_next;
    logic [1:0] part_reg, part_next;
    logic       end_pend_reg, end_pend_next;
    logic       padding_reg, padding_next;
    logic       last_blk_reg, last_blk_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            fill_reg     <= '0;
            round_reg    <= '0;
            part_reg     <= '0;
            end_pend_reg <= 1'b0;
            padding_reg  <= 1'b0;
            last_blk_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            round_reg    <= round_next;
            part_reg     <= part_next;
            end_pend_reg <= end_pend_next;
            padding_reg  <= padding_next;
            last_blk_reg <= last_blk_next;
        end
    end

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = (state_reg == S_EMIT);
    assign part_index = part_reg;
    assign last_part  = (part_reg == 2'd3);

    always_comb
    begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        round_next    = round_reg;
        part_next     = part_reg;
        end_pend_next = end_pend_reg;
        padding_next  = padding_reg;
        last_blk_next = last_blk_reg;

        cmd           = '0;
        cmd.src       = sha_pkg::SRC_DATA;
        cmd.len_idx   = fill_reg[2:0];
        cmd.round_idx = round_reg;
        cmd.part_idx  = part_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (byte_present)
                    begin
                        cmd.push  = 1'b1;
                        fill_next = fill_reg + 6'd1;
                        if (fill_reg == FILL_LAST)
                        begin
                            // block full: compress, then finish if asked
                            end_pend_next = end_of_message;
                            state_next    = S_LOAD;
                        end
                        else if (end_of_message)
                        begin
                            state_next = S_MARK;
                        end
                    end
                    else if (end_of_message)
                    begin
                        state_next = S_MARK;
                    end
                end
            end
            S_MARK:
            begin
                cmd.push      = 1'b1;
                cmd.src       = sha_pkg::SRC_MARK;
                fill_next     = fill_reg + 6'd1;
                padding_next  = 1'b1;
                end_pend_next = 1'b0;
                if (fill_reg == FILL_LAST)
                    state_next = S_LOAD;
                else if (fill_reg == FILL_LEN)
                    state_next = S_LEN;
                else
                    state_next = S_ZERO;
            end
            S_ZERO:
            begin
                cmd.push  = 1'b1;
                cmd.src   = sha_pkg::SRC_ZERO;
                fill_next = fill_reg + 6'd1;
                if (fill_reg == FILL_LAST)
                    state_next = S_LOAD;
                else if (fill_reg == FILL_LEN)
                    state_next = S_LEN;
            end
            S_LEN:
            begin
                cmd.push  = 1'b1;
                cmd.src   = sha_pkg::SRC_LEN;
                fill_next = fill_reg + 6'd1;
                if (fill_reg == FILL_LAST)
                begin
                    last_blk_next = 1'b1;
                    state_next    = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.load   = 1'b1;
                round_next = '0;
                state_next = S_ROUND;
            end
            S_ROUND:
            begin
                cmd.round  = 1'b1;
                round_next = round_reg + 6'd1;
                if (round_reg == FILL_LAST)
                    state_next = S_ADD;
            end
            S_ADD:
            begin
                cmd.add = 1'b1;
                if (last_blk_reg)
                begin
                    part_next  = '0;
                    state_next = S_EMIT;
                end
                else if (padding_reg)
                    state_next = S_ZERO;
                else if (end_pend_reg)
                    state_next = S_MARK;
                else
                    state_next = S_IDLE;
            end
            S_EMIT:
            begin
                if (out_ready)
                begin
                    part_next = part_reg + 2'd1;
                    if (part_reg == 2'd3)
                    begin
                        // back to initial values for the next message
                        cmd.finish    = 1'b1;
                        fill_next     = '0;
                        end_pend_next = 1'b0;
                        padding_next  = 1'b0;
                        last_blk_next = 1'b0;
                        state_next    = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> design/sha_dp.sv
// ============================================================================
// SHA-256 hasher datapath
// Byte shift store, message bit counter, schedule window, working words
// and chaining words with one compression round per cycle.
// ============================================================================
module sha_dp
(
    input  logic              clk,
    input  logic              rst_n,
    input  sha_pkg::dp_cmd_t  cmd,
    input  logic [7:0]        data_byte,
    output logic [63:0]       digest_part
);

    localparam int unsigned W = sha_pkg::WORD_W;

    logic [7:0]   block_reg [sha_pkg::BLOCK_B];
    logic [63:0]  bits_reg;
    logic [W-1:0] win_reg   [sha_pkg::SCHED_N];
    logic [W-1:0] work_reg  [sha_pkg::CHAIN_N];
    logic [W-1:0] chain_reg [sha_pkg::CHAIN_N];

    logic [7:0]   push_byte;
    logic [W-1:0] big_s0, big_s1, ch, maj, t1, t2;
    logic [W-1:0] sm_s0, sm_s1, w_new;
    logic [W-1:0] wa, wb, wc, we, wf, wg, wh, w14, w1;

    always_comb
    begin
        case (cmd.src)
            sha_pkg::SRC_DATA: push_byte = data_byte;
            sha_pkg::SRC_MARK: push_byte = sha_pkg::PAD_MARK;
            sha_pkg::SRC_LEN:  push_byte = bits_reg[{~cmd.len_idx, 3'b000} +: 8];
            default:           push_byte = '0;
        endcase
    end

    assign wa  = work_reg[0];
    assign wb  = work_reg[1];
    assign wc  = work_reg[2];
    assign we  = work_reg[4];
    assign wf  = work_reg[5];
    assign wg  = work_reg[6];
    assign wh  = work_reg[7];
    assign w1  = win_reg[1];
    assign w14 = win_reg[14];

    assign big_s0 = {wa[1:0], wa[31:2]} ^ {wa[12:0], wa[31:13]} ^ {wa[21:0], wa[31:22]};
    assign big_s1 = {we[5:0], we[31:6]} ^ {we[10:0], we[31:11]} ^ {we[24:0], we[31:25]};
    assign ch     = (we & wf) ^ (~we & wg);
    assign maj    = (wa & wb) ^ (wa & wc) ^ (wb & wc);
    assign t1     = wh + big_s1 + ch + sha_pkg::ROUND_K[cmd.round_idx] + win_reg[0];
    assign t2     = big_s0 + maj;

    assign sm_s0 = {w1[6:0], w1[31:7]} ^ {w1[17:0], w1[31:18]} ^ {3'b000, w1[31:3]};
    assign sm_s1 = {w14[16:0], w14[31:17]} ^ {w14[18:0], w14[31:19]}
                 ^ {10'd0, w14[31:10]};
    assign w_new = sm_s1 + win_reg[9] + sm_s0 + win_reg[0];

    assign digest_part = {chain_reg[{cmd.part_idx, 1'b0}], chain_reg[{cmd.part_idx, 1'b1}]};

    // block store: newest byte enters at the top, first byte ends at index 0
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            for (int i = 0; i < sha_pkg::BLOCK_B - 1; i++)
                block_reg[i] <= block_reg[i+1];
            block_reg[sha_pkg::BLOCK_B-1] <= push_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int j = 0; j < sha_pkg::SCHED_N; j++)
                win_reg[j] <= {block_reg[4*j], block_reg[4*j+1],
                               block_reg[4*j+2], block_reg[4*j+3]};
            for (int j = 0; j < sha_pkg::CHAIN_N; j++)
                work_reg[j] <= chain_reg[j];
        end
        else if (cmd.round)
        begin
            // slide the schedule window by one word
            for (int j = 0; j < sha_pkg::SCHED_N - 1; j++)
                win_reg[j] <= win_reg[j+1];
            win_reg[sha_pkg::SCHED_N-1] <= w_new;
            work_reg[7] <= work_reg[6];
            work_reg[6] <= work_reg[5];
            work_reg[5] <= work_reg[4];
            work_reg[4] <= work_reg[3] + t1;
            work_reg[3] <= work_reg[2];
            work_reg[2] <= work_reg[1];
            work_reg[1] <= work_reg[0];
            work_reg[0] <= t1 + t2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_reg <= '0;
            for (int j = 0; j < sha_pkg::CHAIN_N; j++)
                chain_reg[j] <= sha_pkg::INIT_HASH[j];
        end
        else
        begin
            if (cmd.finish)
                bits_reg <= '0;
            else if (cmd.push && (cmd.src == sha_pkg::SRC_DATA))
                bits_reg <= bits_reg + 64'd8;

            if (cmd.finish)
            begin
                for (int j = 0; j < sha_pkg::CHAIN_N; j++)
                    chain_reg[j] <= sha_pkg::INIT_HASH[j];
            end
            else if (cmd.add)
            begin
                for (int j = 0; j < sha_pkg::CHAIN_N; j++)
                    chain_reg[j] <= chain_reg[j] + work_reg[j];
            end
        end
    end

endmodule

>>> design/sha256_byte_stream_hasher.sv
// ============================================================================
// SHA-256 byte stream hasher
// Hashes a message taken one byte per transfer and returns the 256-bit
// digest as four 64-bit transfers, most significant part first.
// ============================================================================
// A message byte is taken while the hasher is idle. When a byte completes a
// 64-byte block, the input stalls while the schedule window and working words
// are loaded, 64 rounds run on the single round unit and the result is folded
// into the chaining words. An end-of-message transfer starts padding, which
// pushes one byte per cycle between compressions into the block store (0x80,
// zeros, then the eight length bytes) and compresses once or, when fewer than
// nine bytes are left in the block, twice; the digest then goes out as four
// transfers, and the input is taken again once the last part is accepted.
module sha256_byte_stream_hasher
(
    input  logic          clk,
    input  logic          rst_n,
    sha_byte_if.sink      byte_in,
    sha_digest_if.source  digest_out
);

    sha_pkg::dp_cmd_t cmd;

    sha_ctrl u_ctrl
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (byte_in.valid),
        .in_ready       (byte_in.ready),
        .byte_present   (byte_in.byte_present),
        .end_of_message (byte_in.end_of_message),
        .out_valid      (digest_out.valid),
        .out_ready      (digest_out.ready),
        .part_index     (digest_out.part_index),
        .last_part      (digest_out.last_part),
        .cmd            (cmd)
    );

    sha_dp u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .data_byte   (byte_in.data_byte),
        .digest_part (digest_out.digest_part)
    );

endmodule
